// ===== rtl/tduart_pkg.sv =====
// Package for the tick-driven UART: item codes, parity modes, register map
// and the request and response transaction structs. No dependencies.
package tduart_pkg;

   // Operation codes carried by a request transaction
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SEND = 2'd1,
      OP_READ = 2'd2
   } op_type;

   // Transmit parity modes; mode three behaves as odd parity
   localparam logic [1:0] PARITY_NONE = 2'd0;
   localparam logic [1:0] PARITY_ODD  = 2'd1;
   localparam logic [1:0] PARITY_EVEN = 2'd2;

   // Register map: word index of each control register
   localparam int          CSR_ADDR_W   = 3;
   localparam logic        CSR_PARITY_IDX = 1'b0;

   // Width of the byte fields on both channels
   localparam int BYTE_W = 8;

   typedef struct packed {
      logic [1:0]        op;
      logic [BYTE_W-1:0] tx_byte;
      logic              rx_line;
   } req_type;

   typedef struct packed {
      logic              tx_line;
      logic              send_accepted;
      logic              rx_ready;
      logic [BYTE_W-1:0] rx_byte;
   } rsp_type;

endpackage

// ===== rtl/tick_driven_uart_tx_rx.sv =====
// Tick-driven UART transmitter and receiver with an output register and an
// APB-style control port. Depends on tduart_pkg.
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    tduart_pkg::req_type (op, tx_byte, rx_line)
//   rsp_      out        rsp_valid/stall    tduart_pkg::rsp_type
//   control   in         psel/penable       paddr, pwdata, prdata, pready
//
// One transaction per clock cycle: each request updates the UART state in the
// cycle it is accepted and its response sits in the output register from the
// next cycle. The request side stalls only while a response is held and the
// response side stalls. Reset is synchronous and clears all control state;
// the transmit pin resets high and parity mode to none.
module tick_driven_uart_tx_rx #(
   parameter int DATA_BITS  = 8,
   parameter int FRAME_BITS = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tduart_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tduart_pkg::rsp_type                 rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tduart_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import tduart_pkg::*;

   localparam int IDX_W = $clog2(FRAME_BITS + 1);
   localparam logic [IDX_W-1:0] FRAME_END = IDX_W'(FRAME_BITS);
   localparam logic [FRAME_BITS-1:0] DATA_MASK =
      {{(FRAME_BITS - DATA_BITS){1'b0}}, {DATA_BITS{1'b1}}};
   localparam logic [FRAME_BITS-1:0] ONE_BIT = {{(FRAME_BITS - 1){1'b0}}, 1'b1};

   // State registers and next values
   logic [1:0]            parity_mode_ff, parity_mode_in;
   logic [FRAME_BITS-1:0] tx_frame_ff, tx_frame_in;
   logic [IDX_W-1:0]      tx_bit_index_ff, tx_bit_index_in;
   logic                  tx_busy_ff, tx_busy_in;
   logic                  tx_pin_ff, tx_pin_in;
   logic [FRAME_BITS-1:0] rx_frame_ff, rx_frame_in;
   logic [IDX_W-1:0]      rx_bit_index_ff, rx_bit_index_in;
   logic                  rx_busy_ff, rx_busy_in;
   logic                  rx_ready_ff, rx_ready_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  csr_write;
   logic [DATA_BITS-1:0]  send_data;
   logic                  parity_en;
   logic                  parity_bit;
   logic [FRAME_BITS-1:0] send_frame;
   logic [IDX_W-1:0]      tx_idx_next;
   logic [IDX_W-1:0]      rx_idx_next;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control port: always ready, one parity register
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite
                      & (paddr[CSR_ADDR_W-1] == CSR_PARITY_IDX);
   assign prdata    = (paddr[CSR_ADDR_W-1] == CSR_PARITY_IDX)
                      ? {30'd0, parity_mode_ff} : 32'd0;

   // Build the transmit frame: start, data LSB first, parity or stop, stops
   always_comb begin
      for (int j = 0; j < DATA_BITS; j++) begin
         send_data[j] = (j < BYTE_W) ? req_data.tx_byte[j % BYTE_W] : 1'b0;
      end
      parity_en  = (parity_mode_ff != PARITY_NONE);
      parity_bit = parity_mode_ff[0] ^ (^send_data);
      for (int i = 0; i < FRAME_BITS; i++) begin
         if (i == 0) begin
            send_frame[i] = 1'b0;
         end else if (i <= DATA_BITS) begin
            send_frame[i] = send_data[(i + DATA_BITS - 1) % DATA_BITS];
         end else if (i == DATA_BITS + 1) begin
            send_frame[i] = parity_en ? parity_bit : 1'b1;
         end else begin
            send_frame[i] = 1'b1;
         end
      end
   end

   assign tx_idx_next = tx_bit_index_ff + IDX_W'(1);
   assign rx_idx_next = rx_bit_index_ff + IDX_W'(1);

   // Next state and response for the accepted transaction
   always_comb begin
      parity_mode_in  = csr_write ? pwdata[1:0] : parity_mode_ff;
      tx_frame_in     = tx_frame_ff;
      tx_bit_index_in = tx_bit_index_ff;
      tx_busy_in      = tx_busy_ff;
      tx_pin_in       = tx_pin_ff;
      rx_frame_in     = rx_frame_ff;
      rx_bit_index_in = rx_bit_index_ff;
      rx_busy_in      = rx_busy_ff;
      rx_ready_in     = rx_ready_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;

      if (req_fire) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.send_accepted = 1'b0;
         rsp_data_in.rx_byte       = '0;
         case (req_data.op)
            OP_TICK: begin
               // advance the transmitter by one bit period
               if (tx_busy_ff) begin
                  tx_pin_in       = tx_frame_ff[0] & 1'b0
                                    | ((tx_frame_ff >> tx_bit_index_ff) & ONE_BIT) != '0;
                  tx_bit_index_in = tx_idx_next;
                  if (tx_idx_next >= FRAME_END) begin
                     tx_busy_in = 1'b0;
                  end
               end
               // sample the line, or detect a start bit while idle
               if (rx_busy_ff) begin
                  if (req_data.rx_line) begin
                     rx_frame_in = rx_frame_ff | (ONE_BIT << rx_bit_index_ff);
                  end
                  rx_bit_index_in = rx_idx_next;
                  if (rx_idx_next >= FRAME_END) begin
                     rx_frame_in = rx_frame_in & DATA_MASK;
                     rx_busy_in  = 1'b0;
                     rx_ready_in = 1'b1;
                  end
               end else if (!req_data.rx_line) begin
                  rx_frame_in     = '0;
                  rx_bit_index_in = '0;
                  rx_busy_in      = 1'b1;
               end
            end
            OP_SEND: begin
               // load a frame only while the transmitter is idle
               if (!tx_busy_ff) begin
                  tx_frame_in               = send_frame;
                  tx_bit_index_in           = '0;
                  tx_busy_in                = 1'b1;
                  rsp_data_in.send_accepted = 1'b1;
               end
            end
            OP_READ: begin
               rsp_data_in.rx_byte = rx_frame_ff[BYTE_W-1:0];
               rx_ready_in         = 1'b0;
            end
            default: begin
            end
         endcase
         rsp_data_in.tx_line  = tx_pin_in;
         rsp_data_in.rx_ready = rx_ready_in;
      end
   end

   // Hold state and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         parity_mode_ff  <= PARITY_NONE;
         tx_frame_ff     <= '0;
         tx_bit_index_ff <= '0;
         tx_busy_ff      <= 1'b0;
         tx_pin_ff       <= 1'b1;
         rx_frame_ff     <= '0;
         rx_bit_index_ff <= '0;
         rx_busy_ff      <= 1'b0;
         rx_ready_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         parity_mode_ff  <= parity_mode_in;
         tx_frame_ff     <= tx_frame_in;
         tx_bit_index_ff <= tx_bit_index_in;
         tx_busy_ff      <= tx_busy_in;
         tx_pin_ff       <= tx_pin_in;
         rx_frame_ff     <= rx_frame_in;
         rx_bit_index_ff <= rx_bit_index_in;
         rx_busy_ff      <= rx_busy_in;
         rx_ready_ff     <= rx_ready_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // A busy transmitter never points past its frame
   a_tx_index: assert property (@(posedge clock) disable iff (reset)
      tx_busy_ff |-> (tx_bit_index_ff < FRAME_END))
      else $error("transmit bit index beyond frame while busy");

   // A busy receiver never points past its frame
   a_rx_index: assert property (@(posedge clock) disable iff (reset)
      rx_busy_ff |-> (rx_bit_index_ff < FRAME_END))
      else $error("receive bit index beyond frame while busy");

   // A send to a busy transmitter is refused
   a_busy_send: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.op == OP_SEND && tx_busy_ff) |=> !rsp_data.send_accepted)
      else $error("send accepted while transmitter busy");

   // A read always leaves the ready flag clear
   a_read_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.op == OP_READ) |=> (rsp_valid && !rsp_data.rx_ready))
      else $error("ready flag still set after read");

endmodule

// ===== test/tb_tick_driven_uart_tx_rx.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tick_driven_uart_tx_rx: a queued request driver, a response
// monitor checked against an in-bench UART predictor, and parity register writes.
// Depends on tduart_pkg and the tick_driven_uart_tx_rx RTL.
module tb_tick_driven_uart_tx_rx;
   import tduart_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] PARITY_MODE3 = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] PARITY_ADDR = {CSR_PARITY_IDX, 2'b00};
   localparam int PHASE_ITEMS = 220;
   localparam int NUM_PHASES = 6;
   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_HOLD = 250;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_kind;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   tick_driven_uart_tx_rx uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #2 clock = ~clock;

   // UART state as the block should hold it
   logic [1:0]  uart_parity = PARITY_NONE;
   logic [10:0] uart_tx_frame = '0;
   logic [3:0]  uart_tx_idx = '0;
   logic        uart_tx_busy = 1'b0;
   logic        uart_tx_pin = 1'b1;
   logic [10:0] uart_rx_frame = '0;
   logic [3:0]  uart_rx_idx = '0;
   logic        uart_rx_busy = 1'b0;
   logic        uart_rx_ready = 1'b0;

   req_type queued_requests[$];
   rsp_type uart_results_due[$];
   int      fail_count = 0;
   int      phase_items = 0;
   int      n_sent = 0;

   // Advance the UART by one request and return the response it should give
   function automatic rsp_type predict_uart_item(req_type r);
      rsp_type     res;
      logic [31:0] frame;
      logic        has_par;
      res = '0;
      case (r.op)
         OP_TICK: begin
            if (uart_tx_busy) begin
               frame = 32'(uart_tx_frame) >> uart_tx_idx;
               uart_tx_pin = frame[0];
               uart_tx_idx = uart_tx_idx + 4'd1;
               if (uart_tx_idx >= 4'd11)
                  uart_tx_busy = 1'b0;
            end
            if (uart_rx_busy) begin
               if (r.rx_line && uart_rx_idx < 4'd11)
                  uart_rx_frame[uart_rx_idx] = 1'b1;
               uart_rx_idx = uart_rx_idx + 4'd1;
               if (uart_rx_idx >= 4'd11) begin
                  uart_rx_frame = {3'b000, uart_rx_frame[7:0]};
                  uart_rx_busy = 1'b0;
                  uart_rx_ready = 1'b1;
               end
            end else if (!r.rx_line) begin
               uart_rx_frame = '0;
               uart_rx_idx = '0;
               uart_rx_busy = 1'b1;
            end
         end
         OP_SEND: begin
            if (!uart_tx_busy) begin
               has_par = (uart_parity != PARITY_NONE);
               // stop bits fill everything above the data and optional parity bit
               frame = ~((32'd1 << (9 + has_par)) - 32'd1);
               frame |= 32'(r.tx_byte) << 1;
               if (has_par)
                  frame[9] = uart_parity[0] ^ (^r.tx_byte);
               uart_tx_frame = frame[10:0];
               uart_tx_idx = '0;
               uart_tx_busy = 1'b1;
               res.send_accepted = 1'b1;
            end
         end
         OP_READ: begin
            res.rx_byte = uart_rx_frame[7:0];
            uart_rx_ready = 1'b0;
         end
         default: ;
      endcase
      res.tx_line = uart_tx_pin;
      res.rx_ready = uart_rx_ready;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic add_req(input logic [1:0] code, input logic [7:0] data, input logic level);
      queued_requests.push_back('{code, data, level});
      phase_items++;
   endtask

   // Write the parity register over the control port and read it back
   task automatic write_parity(input logic [1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PARITY_ADDR;
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      uart_parity = value;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[1:0] !== value)
         report_mismatch("parity_mode readback", 32'(value), 32'(prdata[1:0]));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Extremes, every op, busy send, idle tick, read without data, all-ones frame
   task automatic add_directed();
      add_req(OP_READ, 8'h00, 1'b0);
      add_req(OP_UNUSED, 8'hff, 1'b0);
      add_req(OP_TICK, 8'h00, 1'b1);
      add_req(OP_SEND, 8'h00, 1'b1);
      add_req(OP_SEND, 8'hff, 1'b0);
      add_req(OP_TICK, 8'hff, 1'b0);
      repeat (11) add_req(OP_TICK, 8'h00, 1'b1);
      add_req(OP_READ, 8'hff, 1'b1);
      add_req(OP_READ, 8'h00, 1'b0);
      add_req(OP_SEND, 8'hff, 1'b0);
   endtask

   // A receive frame, mostly with valid stop bits and a transmit beside it, stray ops mixed in
   task automatic add_frame_exchange();
      logic [10:0] samples;
      int          lead;
      samples[7:0] = rand_byte();
      samples[10:8] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
      if ($urandom_range(0, 4) != 0)
         add_req(OP_SEND, rand_byte(), rand_bit());
      lead = $urandom_range(0, 2);
      repeat (lead) add_req(OP_TICK, rand_byte(), 1'b1);
      add_req(OP_TICK, rand_byte(), 1'b0);
      for (int i = 0; i < 11; i++) begin
         if ($urandom_range(0, 9) == 0)
            add_req(rand_bit() ? OP_SEND : OP_READ, rand_byte(), rand_bit());
         add_req(OP_TICK, rand_byte(), samples[i]);
      end
      // leave some bytes unread so the next frame overruns them
      if ($urandom_range(0, 3) != 0)
         add_req(OP_READ, rand_byte(), rand_bit());
   endtask

   task automatic add_random_seq();
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         add_frame_exchange();
      end else if (kind <= 7) begin
         n = $urandom_range(1, 8);
         repeat (n) add_req(2'($urandom_range(0, 3)), rand_byte(), rand_bit());
      end else if (kind == 8) begin
         // broken frame: start, a few samples, then a read mid-reception
         add_req(OP_TICK, rand_byte(), 1'b0);
         n = $urandom_range(0, 10);
         repeat (n) add_req(OP_TICK, rand_byte(), rand_bit());
         add_req(OP_READ, rand_byte(), rand_bit());
      end else begin
         // transmit frame with a busy send inside and a send right as it ends
         add_req(OP_SEND, rand_byte(), rand_bit());
         n = $urandom_range(0, 10);
         for (int i = 0; i < 11; i++) begin
            if (i == n)
               add_req(OP_SEND, rand_byte(), rand_bit());
            add_req(OP_TICK, rand_byte(), 1'b1);
         end
         add_req(OP_SEND, rand_byte(), rand_bit());
      end
   endtask

   // Driver: present queued transactions in bursts, hold while stalled
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            uart_results_due.push_back(predict_uart_item(req_data));
            n_sent <= n_sent + 1;
         end
         if (req_valid && req_stall) begin
            // hold the stalled transaction
         end else if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (queued_requests.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= queued_requests.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall on changing patterns, with one long hold-off
   int        hold_left = 0;
   int        pattern_left = 0;
   stall_kind stall_pattern = STALL_NONE;
   logic      long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         pattern_left <= 0;
         stall_pattern <= STALL_NONE;
         long_hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!long_hold_done && n_sent >= 400) begin
         long_hold_done <= 1'b1;
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
      end else begin
         case (stall_pattern)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= pattern_left[0];
         endcase
         if (pattern_left == 0) begin
            stall_pattern <= stall_kind'($urandom_range(0, 3));
            pattern_left <= $urandom_range(16, 80);
         end else begin
            pattern_left <= pattern_left - 1;
         end
      end
   end

   // Monitor: check each accepted response against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (uart_results_due.size() == 0) begin
            report_mismatch("response with nothing outstanding", 0, 32'(rsp_data));
         end else begin
            want = uart_results_due.pop_front();
            if (rsp_data.tx_line !== want.tx_line)
               report_mismatch("tx_line", 32'(want.tx_line), 32'(rsp_data.tx_line));
            if (rsp_data.send_accepted !== want.send_accepted)
               report_mismatch("send_accepted", 32'(want.send_accepted),
                               32'(rsp_data.send_accepted));
            if (rsp_data.rx_ready !== want.rx_ready)
               report_mismatch("rx_ready", 32'(want.rx_ready), 32'(rsp_data.rx_ready));
            if (rsp_data.rx_byte !== want.rx_byte)
               report_mismatch("rx_byte", 32'(want.rx_byte), 32'(rsp_data.rx_byte));
         end
      end
   end

   // Watchdog: drop out if no transaction moves for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Phases: set parity, queue stimulus, drain before the next register write
   initial begin
      logic [1:0] mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       mode = PARITY_NONE;
            1:       mode = PARITY_ODD;
            2:       mode = PARITY_EVEN;
            3:       mode = PARITY_MODE3;
            default: mode = 2'($urandom_range(0, 3));
         endcase
         write_parity(mode);
         phase_items = 0;
         if (phase == 0)
            add_directed();
         while (phase_items < PHASE_ITEMS)
            add_random_seq();
         while (queued_requests.size() != 0 || req_valid || uart_results_due.size() != 0)
            @(posedge clock);
         repeat (3) @(posedge clock);
      end
      repeat (4) @(posedge clock);
      if (fail_count == 0 && uart_results_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tduart_pkg.sv
rtl/tick_driven_uart_tx_rx.sv
test/tb_tick_driven_uart_tx_rx.sv
